// ----- rtl/core/keyframe_linear_interpolator_defines.svh -----
// Assertion macros for the keyframe interpolator checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define KLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kli_pkg.sv -----
// Shared types and constants of the keyframe interpolator.
// No dependencies; used by every module of the block except kli_ram.
package kli_pkg;

  localparam int TIME_W     = 24;
  localparam int VAL_W      = 24;
  localparam int KEY_IDX_W  = 6;
  localparam int CNT_W      = 7;
  localparam int SEG_W      = 6;
  localparam int FRAC_W     = 16;
  localparam int FAC_W      = FRAC_W + 1;
  localparam int DIV_STEPS  = FRAC_W;
  localparam int COMP_N     = 3;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 80;

  localparam logic [FAC_W-1:0] FACTOR_ONE  = FAC_W'(1) << FRAC_W;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PREP,
    ST_CLASS,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } kli_state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] z;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] x;
    logic [TIME_W-1:0]       t;
  } kli_key_t;

  typedef struct packed {
    logic [TIME_W-1:0]       query_time;
    logic signed [VAL_W-1:0] value_z;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_x;
    logic [TIME_W-1:0]       key_time;
    logic [KEY_IDX_W-1:0]    key_index;
  } kli_in_t;

  typedef struct packed {
    logic wr_key;
    logic start;
    logic step;
    logic seg_hit;
    logic seg_last;
    logic prep;
    logic classify;
    logic div_step;
    logic mul;
    logic add;
    logic out_load;
  } kli_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic div_run;
    logic div_done;
    logic comp_last;
    logic out_free;
  } kli_sts_t;

endpackage

// ----- rtl/core/kli_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kli_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/kli_ctrl.sv -----
// Sequencer of the keyframe interpolator: key writes, search, divide, blend, output.
// Depends on kli_pkg.
module kli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              kind_i,
  output logic              s_ready_o,
  input  kli_pkg::kli_sts_t sts_i,
  output kli_pkg::kli_cmd_t cmd_o
);

  kli_pkg::kli_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kli_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      kli_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (kind_i == kli_pkg::KIND_WRITE) begin
            cmd_o.wr_key = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = kli_pkg::ST_SEARCH;
          end
        end
      end
      kli_pkg::ST_SEARCH: begin
        if (sts_i.hit) begin
          cmd_o.seg_hit = 1'b1;
          state_d       = kli_pkg::ST_PREP;
        end else if (sts_i.last) begin
          cmd_o.seg_last = 1'b1;
          state_d        = kli_pkg::ST_MUL;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      kli_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = kli_pkg::ST_CLASS;
      end
      kli_pkg::ST_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = sts_i.div_run ? kli_pkg::ST_DIV : kli_pkg::ST_MUL;
      end
      kli_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = kli_pkg::ST_MUL;
        end
      end
      kli_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = kli_pkg::ST_ADD;
      end
      kli_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = sts_i.comp_last ? kli_pkg::ST_OUT : kli_pkg::ST_MUL;
      end
      kli_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = kli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/kli_dp.sv -----
// Datapath of the keyframe interpolator: key table, search compare,
// serial divider, shared multiplier and output register.
// Depends on kli_pkg and kli_ram.
module kli_dp #(
  parameter int MAX_KEYS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [kli_pkg::CNT_W-1:0]           cfg_data_i,
  input  kli_pkg::kli_in_t                    in_i,
  input  kli_pkg::kli_cmd_t                   cmd_i,
  output kli_pkg::kli_sts_t                   sts_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic signed [kli_pkg::VAL_W-1:0]    out_x_o,
  output logic signed [kli_pkg::VAL_W-1:0]    out_y_o,
  output logic signed [kli_pkg::VAL_W-1:0]    out_z_o,
  output logic [kli_pkg::SEG_W-1:0]           segment_o
);

  localparam int AW        = $clog2(MAX_KEYS);
  localparam int TIME_W    = kli_pkg::TIME_W;
  localparam int VAL_W     = kli_pkg::VAL_W;
  localparam int FRAC_W    = kli_pkg::FRAC_W;
  localparam int FAC_W     = kli_pkg::FAC_W;
  localparam int SEG_W     = kli_pkg::SEG_W;
  localparam int COMP_N    = kli_pkg::COMP_N;
  localparam int DCNT_W    = $clog2(kli_pkg::DIV_STEPS);
  localparam int CMP_W     = $clog2(COMP_N);
  localparam int DIFF_W    = VAL_W + 1;
  localparam int PROD_W    = FAC_W + 1 + DIFF_W;
  localparam int KEY_W     = $bits(kli_pkg::kli_key_t);
  localparam int unsigned MAXK = MAX_KEYS;

  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(kli_pkg::DIV_STEPS - 1);
  localparam logic [CMP_W-1:0]  COMP_LAST = CMP_W'(COMP_N - 1);

  logic [kli_pkg::CNT_W-1:0] key_count_q;
  logic [AW-1:0]             last_idx;

  logic [TIME_W-1:0]         qtime_q;
  logic [AW-1:0]             addr_q, didx_q, seg_q;
  kli_pkg::kli_key_t         prev_q, rdata, wdata;
  logic [KEY_W-1:0]          rdata_raw;
  logic                      wr_ok;
  logic [AW-1:0]             raddr;

  logic [TIME_W-1:0]         t0_q, t1_q;
  logic signed [VAL_W-1:0]   a_q [COMP_N];
  logic signed [VAL_W-1:0]   b_q [COMP_N];
  logic signed [VAL_W-1:0]   res_q [COMP_N];
  logic [CMP_W-1:0]          comp_q;

  logic                      den_neg;
  logic signed [TIME_W:0]    num_q;
  logic [TIME_W-1:0]         den_q;
  logic [TIME_W-1:0]         rem_q;
  logic [TIME_W:0]           rem_x2;
  logic                      rem_ge;
  logic [DCNT_W-1:0]         dcnt_q;
  logic [FAC_W-1:0]          fac_q;
  logic                      div_run;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [FAC_W:0]     fac_s;
  logic signed [PROD_W-1:0]  prod_q;

  logic                      m_valid_q;
  logic signed [VAL_W-1:0]   ox_q, oy_q, oz_q;
  logic [SEG_W-1:0]          oseg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= kli_pkg::COUNT_RESET;
    end else if (cfg_valid_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (key_count_q == '0) begin
      last_idx = '0;
    end else if (32'(key_count_q) > MAXK) begin
      last_idx = AW'(MAXK - 1);
    end else begin
      last_idx = AW'(key_count_q - 1'b1);
    end
  end

  assign wr_ok   = 32'(in_i.key_index) < MAXK;
  assign wdata.t = in_i.key_time;
  assign wdata.x = in_i.value_x;
  assign wdata.y = in_i.value_y;
  assign wdata.z = in_i.value_z;
  assign raddr   = cmd_i.start ? '0 : addr_q;

  kli_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_kli_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_key && wr_ok),
    .waddr_i (AW'(in_i.key_index)),
    .wdata_i (wdata),
    .re_i    (cmd_i.start || cmd_i.step),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = kli_pkg::kli_key_t'(rdata_raw);

  assign den_neg = t1_q < t0_q;
  assign rem_x2  = {rem_q, 1'b0};
  assign rem_ge  = rem_x2 >= {1'b0, den_q};
  assign div_run = (den_q != '0) && (num_q > 0) && (num_q < $signed({1'b0, den_q}));
  assign diff    = DIFF_W'(b_q[comp_q]) - DIFF_W'(a_q[comp_q]);
  assign fac_s   = $signed({1'b0, fac_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qtime_q <= in_i.query_time;
      addr_q  <= AW'(1);
      didx_q  <= '0;
    end
    if (cmd_i.step) begin
      prev_q <= rdata;
      addr_q <= addr_q + 1'b1;
      didx_q <= didx_q + 1'b1;
    end
    if (cmd_i.seg_hit) begin
      seg_q  <= didx_q - 1'b1;
      t0_q   <= prev_q.t;
      t1_q   <= rdata.t;
      a_q[0] <= prev_q.x;
      a_q[1] <= prev_q.y;
      a_q[2] <= prev_q.z;
      b_q[0] <= rdata.x;
      b_q[1] <= rdata.y;
      b_q[2] <= rdata.z;
      comp_q <= '0;
    end
    if (cmd_i.seg_last) begin
      seg_q  <= didx_q;
      a_q[0] <= rdata.x;
      a_q[1] <= rdata.y;
      a_q[2] <= rdata.z;
      b_q[0] <= rdata.x;
      b_q[1] <= rdata.y;
      b_q[2] <= rdata.z;
      fac_q  <= '0;
      comp_q <= '0;
    end
    if (cmd_i.prep) begin
      if (den_neg) begin
        num_q <= $signed({1'b0, t0_q}) - $signed({1'b0, qtime_q});
        den_q <= t0_q - t1_q;
      end else begin
        num_q <= $signed({1'b0, qtime_q}) - $signed({1'b0, t0_q});
        den_q <= t1_q - t0_q;
      end
    end
    if (cmd_i.classify) begin
      rem_q  <= num_q[TIME_W-1:0];
      dcnt_q <= '0;
      if (den_q == '0) begin
        fac_q <= kli_pkg::FACTOR_ONE;
      end else if (num_q <= 0) begin
        fac_q <= '0;
      end else if (num_q >= $signed({1'b0, den_q})) begin
        fac_q <= kli_pkg::FACTOR_ONE;
      end else begin
        fac_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? TIME_W'(rem_x2 - {1'b0, den_q}) : rem_x2[TIME_W-1:0];
      fac_q  <= {fac_q[FAC_W-2:0], rem_ge};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.mul) begin
      prod_q <= fac_s * diff;
    end
    if (cmd_i.add) begin
      res_q[comp_q] <= a_q[comp_q] + prod_q[FRAC_W +: VAL_W];
      comp_q        <= comp_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      ox_q   <= res_q[0];
      oy_q   <= res_q[1];
      oz_q   <= res_q[2];
      oseg_q <= SEG_W'(seg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign sts_o.hit       = (didx_q != '0) && (qtime_q < rdata.t);
  assign sts_o.last      = didx_q == last_idx;
  assign sts_o.div_run   = div_run;
  assign sts_o.div_done  = dcnt_q == DCNT_LAST;
  assign sts_o.comp_last = comp_q == COMP_LAST;
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign out_x_o   = ox_q;
  assign out_y_o   = oy_q;
  assign out_z_o   = oz_q;
  assign segment_o = oseg_q;

endmodule

// ----- rtl/core/keyframe_linear_interpolator.sv -----
// Keyframe writes are taken back to back. A query runs search, prep, classify, then a
// serial divider when the factor lies strictly between 0 and 1, then multiply and add per
// component and output; past the last key the factor is 0 and the last key is output.
// The search reads one key a cycle from the table RAM; one item at a time, the next
// taken in the same cycle the result turns valid; a waiting result does not stall input.
// Reset clears control state and sets key_count to 1; the key table is undefined until written.
module keyframe_linear_interpolator #(
  parameter int MAX_KEYS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kli_pkg::CNT_W-1:0]          cfg_data_i,     // key_count
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // key_index, key_time, value_x, value_y, value_z, query_time, zero pad
  input  logic [kli_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic [0:0]                         s_axis_tuser_i, // kind
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_x, out_y, out_z, segment, zero pad
  output logic [kli_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  localparam int VAL_W  = kli_pkg::VAL_W;
  localparam int SEG_W  = kli_pkg::SEG_W;
  localparam int IN_W   = $bits(kli_pkg::kli_in_t);

  kli_pkg::kli_cmd_t       cmd;
  kli_pkg::kli_sts_t       sts;
  kli_pkg::kli_in_t        in_word;
  logic signed [VAL_W-1:0] out_x, out_y, out_z;
  logic [SEG_W-1:0]        segment;

  assign cfg_ready_o = 1'b1;
  assign in_word     = kli_pkg::kli_in_t'(s_axis_tdata_i[IN_W-1:0]);

  kli_ctrl u_kli_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .kind_i    (s_axis_tuser_i[0]),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  kli_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_kli_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .segment_o   (segment)
  );

  assign m_axis_tdata_o = kli_pkg::OUT_DATA_W'({segment, out_z, out_y, out_x});

endmodule

// ----- rtl/core/kli_checker.sv -----
// Port-level assertions for the keyframe interpolator, bound to the top level.
// Depends on kli_pkg and keyframe_linear_interpolator_defines.svh.
`include "keyframe_linear_interpolator_defines.svh"

module kli_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [0:0]                     s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [kli_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic s_acc;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  `KLI_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "output word changed while stalled")

  `KLI_ASSERT_NEXT(a_write_no_result, s_acc && (s_axis_tuser_i[0] == kli_pkg::KIND_WRITE), !$rose(m_axis_tvalid_o), "keyframe write produced a result")

  `KLI_ASSERT_NEXT(a_query_busy, s_acc && (s_axis_tuser_i[0] == kli_pkg::KIND_QUERY), !s_axis_tready_o, "input taken during a query")

  `KLI_ASSERT_NOW(a_result_after_busy, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o), "result appeared without a query in progress")

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (.*);
